[design/dilt_pkg.sv]
package dilt_pkg;

	localparam int ID_W  = 32;
	localparam int POS_W = 10;
	localparam int CNT_W = 11;

	// request opcodes
	localparam logic [2:0] OP_ADD      = 3'd0;
	localparam logic [2:0] OP_REMOVE   = 3'd1;
	localparam logic [2:0] OP_CONTAINS = 3'd2;
	localparam logic [2:0] OP_READ     = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// result status codes
	localparam logic [2:0] STS_OK    = 3'd0;
	localparam logic [2:0] STS_DUP   = 3'd1;
	localparam logic [2:0] STS_FULL  = 3'd2;
	localparam logic [2:0] STS_MISS  = 3'd3;
	localparam logic [2:0] STS_RANGE = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       load;        // latch request, rewind walk index
		logic       scan;        // step the duplicate/match scan
		logic       shift_init;  // start compaction after the matched entry
		logic       shift;       // step the compaction
		logic       rd_pos;      // read the entry at the requested position
		logic       append;      // write key at the tail, count up
		logic       dec;         // count down
		logic       zero;        // count to zero
		logic       res_set;     // capture result fields below
		logic [2:0] res_status;
		logic       res_hit;
		logic       res_take_id; // id_out from read data, else zero
		logic       out_load;    // move result into output register
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       match;     // entry in flight equals the key
		logic       walk_end;  // no more entries to issue and none in flight
		logic       pos_ok;    // position below count
		logic       full;
		logic       out_free;  // output register can take a result
	} sts_t;

endpackage

[design/dilt_ram.sv]
module dilt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/dilt_datapath.sv]
module dilt_datapath #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [47:0]    s_tdata,
	input  logic [2:0]     s_tuser,
	input  dilt_pkg::cmd_t cmd,
	output dilt_pkg::sts_t sts,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [47:0]    m_tdata,
	output logic [3:0]     m_tuser
);

	import dilt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [ID_W-1:0]  key_q;
	logic [POS_W-1:0] pos_q;
	logic [2:0]       op_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    idx_s1;
	logic             vld_s1;

	logic [2:0]       res_status_q;
	logic             res_hit_q;
	logic [ID_W-1:0]  res_id_q;

	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;
	logic [3:0]       m_tuser_q;

	logic             issue;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [ID_W-1:0]  wdata;
	logic [ID_W-1:0]  rdata;

	assign issue = (cmd.scan | cmd.shift) && (idx_q < cnt_q);
	assign raddr = cmd.rd_pos ? AW'(pos_q) : AW'(idx_q);
	assign we    = cmd.append | (cmd.shift & vld_s1);
	// compaction writes each entry one place below where it was read
	assign waddr = cmd.append ? AW'(cnt_q) : AW'(idx_s1 - CW'(1));
	assign wdata = cmd.append ? key_q : rdata;

	dilt_ram #(
		.WIDTH(ID_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.op       = op_q;
		sts.match    = vld_s1 && (rdata == key_q);
		sts.walk_end = !vld_s1 && (idx_q >= cnt_q);
		sts.pos_ok   = PW'(pos_q) < PW'(cnt_q);
		sts.full     = cnt_q >= CW'(CAPACITY);
		sts.out_free = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= s_tdata[ID_W-1:0];
			pos_q <= s_tdata[ID_W+POS_W-1:ID_W];
			op_q  <= s_tuser;
		end
		if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.shift_init) begin
			idx_q <= idx_s1 + CW'(1);
		end else if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		idx_s1 <= idx_q;
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_hit_q    <= cmd.res_hit;
			res_id_q     <= cmd.res_take_id ? rdata : '0;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {5'b0, CNT_W'(cnt_q), res_id_q};
			m_tuser_q <= {res_hit_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.zero) begin
				cnt_q <= '0;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			vld_s1 <= issue;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[design/dilt_ctrl.sv]
module dilt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  dilt_pkg::sts_t sts,
	output dilt_pkg::cmd_t cmd
);

	import dilt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_ADD, OP_REMOVE, OP_CONTAINS: begin
						state_d = S_SCAN;
					end
					OP_READ: begin
						if (sts.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_READ;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STS_RANGE;
							state_d        = S_RESP;
						end
					end
					OP_CLEAR: begin
						cmd.zero       = 1'b1;
						cmd.res_set    = 1'b1;
						cmd.res_status = STS_OK;
						cmd.res_hit    = 1'b1;
						state_d        = S_RESP;
					end
					default: begin
						// unused opcode: answer ok, no hit, nothing changes
						cmd.res_set    = 1'b1;
						cmd.res_status = STS_OK;
						state_d        = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.match) begin
					case (sts.op)
						OP_ADD: begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STS_DUP;
							state_d        = S_RESP;
						end
						OP_REMOVE: begin
							cmd.shift_init = 1'b1;
							state_d        = S_SHIFT;
						end
						default: begin
							cmd.res_set    = 1'b1;
							cmd.res_status = STS_OK;
							cmd.res_hit    = 1'b1;
							state_d        = S_RESP;
						end
					endcase
				end else if (sts.walk_end) begin
					cmd.res_set = 1'b1;
					state_d     = S_RESP;
					if (sts.op == OP_ADD) begin
						if (sts.full) begin
							cmd.res_status = STS_FULL;
						end else begin
							cmd.append     = 1'b1;
							cmd.res_status = STS_OK;
							cmd.res_hit    = 1'b1;
						end
					end else begin
						cmd.res_status = STS_MISS;
					end
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.walk_end) begin
					cmd.dec        = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_status = STS_OK;
					cmd.res_hit    = 1'b1;
					state_d        = S_RESP;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_READ: begin
				cmd.res_set     = 1'b1;
				cmd.res_status  = STS_OK;
				cmd.res_hit     = 1'b1;
				cmd.res_take_id = 1'b1;
				state_d         = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[design/dedup_id_list_table.sv]
// channel   dir  tdata (low bit up)                   tuser (low bit up)
// s_*       in   song_id[31:0], position[41:32]       opcode[2:0]
// m_*       out  id_out[31:0], count_out[42:32]       status[2:0], hit[3]
//
// One request at a time. Add, remove and contains scan one entry per cycle
// through the single RAM read port and stop at the first matching entry.
// Remove then moves each later entry down one place.
// Reset empties the list at once; the RAM itself is never cleared.
// A finished result waits in the output register while the next request is
// taken; the block stalls only when a new result meets a full output register.
module dedup_id_list_table #(
	parameter int CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // song_id[31:0], position[41:32], zero pad
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // id_out[31:0], count_out[42:32], zero pad
	output logic [3:0]  m_tuser    // status[2:0], hit[3]
);

	import dilt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dilt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dilt_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

[design/dilt_checker.sv]
module dilt_checker #(
	parameter int CAPACITY = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [3:0]  m_tuser
);

	import dilt_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[42:32]) <= CAPACITY) || (CAPACITY > 2047))
		else $error("count above capacity");

	// a failed request never reports a hit or an identifier
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != STS_OK) |-> !m_tuser[3] && (m_tdata[31:0] == '0))
		else $error("failed request with hit or identifier");

endmodule

bind dedup_id_list_table dilt_checker #(.CAPACITY(CAPACITY)) u_dilt_checker (.*);

[test/tb_dedup_id_list_table.sv]
module tb_dedup_id_list_table;
	timeunit 1ns;
	timeprecision 1ps;

	import dilt_pkg::*;

	localparam int LIST_CAP    = 1024;
	localparam int TAIL_CYCLES = 2 * LIST_CAP + 64;
	localparam int N_RANDOM    = 560;

	// opcodes the block must ignore
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	typedef struct packed {
		logic [2:0]       status;
		logic             hit;
		logic [ID_W-1:0]  id_out;
		logic [CNT_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [ID_W-1:0]  key;
		logic [POS_W-1:0] pos;
		logic             fixed;  // want below is used instead of the predictor
		result_t          want;
	} dir_row_t;

	localparam int DIR_N = 25;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{OP_READ,       32'h00000000, 10'd0,    1'b1, '{STS_RANGE, 1'b0, 32'h0, 11'd0}},
		'{OP_REMOVE,     32'h00000000, 10'd0,    1'b1, '{STS_MISS,  1'b0, 32'h0, 11'd0}},
		'{OP_CONTAINS,   32'hFFFFFFFF, 10'd0,    1'b1, '{STS_MISS,  1'b0, 32'h0, 11'd0}},
		'{OP_ADD,        32'h80000000, 10'd0,    1'b1, '{STS_OK,    1'b1, 32'h0, 11'd1}},
		'{OP_ADD,        32'h7FFFFFFF, 10'd1023, 1'b1, '{STS_OK,    1'b1, 32'h0, 11'd2}},
		'{OP_ADD,        32'h00000000, 10'd0,    1'b1, '{STS_OK,    1'b1, 32'h0, 11'd3}},
		'{OP_ADD,        32'hFFFFFFFF, 10'd0,    1'b1, '{STS_OK,    1'b1, 32'h0, 11'd4}},
		'{OP_ADD,        32'h80000000, 10'd0,    1'b1, '{STS_DUP,   1'b0, 32'h0, 11'd4}},
		'{OP_ADD,        32'h00000000, 10'd0,    1'b0, '0},
		'{OP_READ,       32'h00000000, 10'd0,    1'b1,
			'{STS_OK, 1'b1, 32'h80000000, 11'd4}},
		'{OP_READ,       32'hFFFFFFFF, 10'd3,    1'b1,
			'{STS_OK, 1'b1, 32'hFFFFFFFF, 11'd4}},
		'{OP_READ,       32'h00000000, 10'd4,    1'b1, '{STS_RANGE, 1'b0, 32'h0, 11'd4}},
		'{OP_READ,       32'h00000000, 10'd1023, 1'b1, '{STS_RANGE, 1'b0, 32'h0, 11'd4}},
		'{OP_CONTAINS,   32'h7FFFFFFF, 10'd0,    1'b0, '0},
		'{OP_REMOVE,     32'h7FFFFFFF, 10'd0,    1'b0, '0},
		'{OP_READ,       32'h00000000, 10'd1,    1'b0, '0},
		'{OP_REMOVE,     32'hFFFFFFFF, 10'd0,    1'b0, '0},
		'{OP_REMOVE,     32'h80000000, 10'd0,    1'b0, '0},
		'{OP_REMOVE,     32'h80000000, 10'd0,    1'b0, '0},
		'{OP_UNUSED_LO,  32'h5A5A5A5A, 10'd1023, 1'b1, '{STS_OK,    1'b0, 32'h0, 11'd1}},
		'{OP_UNUSED_MID, 32'hA5A5A5A5, 10'd0,    1'b0, '0},
		'{OP_UNUSED_HI,  32'h00000000, 10'd0,    1'b0, '0},
		'{OP_CLEAR,      32'hFFFFFFFF, 10'd0,    1'b1, '{STS_OK,    1'b1, 32'h0, 11'd0}},
		'{OP_READ,       32'h00000000, 10'd0,    1'b1, '{STS_RANGE, 1'b0, 32'h0, 11'd0}},
		'{OP_ADD,        32'h00000001, 10'd0,    1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // song_id[31:0], position[41:32], zero pad
	logic [2:0]  s_tuser = '0;   // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // id_out[31:0], count_out[42:32], zero pad
	logic [3:0]  m_tuser;        // status[2:0], hit[3]

	dedup_id_list_table #(.CAPACITY(LIST_CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the list
	logic [ID_W-1:0] list_ids [LIST_CAP];
	int              list_len = 0;
	int              peak_len = 0;

	result_t pending_results [$];

	int n_sent = 0;
	int n_results = 0;
	int n_errors = 0;
	int burst_left = 0;
	int status_seen [5] = '{default: 0};

	function automatic int index_of(logic [ID_W-1:0] key);
		for (int i = 0; i < list_len; i++) begin
			if (list_ids[i] == key)
				return i;
		end
		return list_len;
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] key;
		do key = $urandom; while (index_of(key) < list_len);
		return key;
	endfunction

	// applies one request to the shadow list and returns what the block should answer
	function automatic result_t apply_list_op(logic [2:0] op, logic [ID_W-1:0] key,
		logic [POS_W-1:0] pos);
		result_t r;
		int at;
		r = '0;
		at = index_of(key);
		case (op)
			OP_ADD: begin
				// duplicate wins over full
				if (at < list_len)
					r.status = STS_DUP;
				else if (list_len >= LIST_CAP)
					r.status = STS_FULL;
				else begin
					list_ids[list_len] = key;
					list_len++;
					r.hit = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (at < list_len) begin
					for (int j = at; j + 1 < list_len; j++)
						list_ids[j] = list_ids[j + 1];
					list_len--;
					r.hit = 1'b1;
				end else
					r.status = STS_MISS;
			end
			OP_CONTAINS: begin
				if (at < list_len)
					r.hit = 1'b1;
				else
					r.status = STS_MISS;
			end
			OP_READ: begin
				if (pos < list_len) begin
					r.id_out = list_ids[pos];
					r.hit = 1'b1;
				end else
					r.status = STS_RANGE;
			end
			OP_CLEAR: begin
				list_len = 0;
				r.hit = 1'b1;
			end
			default: ;
		endcase
		r.count = CNT_W'(list_len);
		if (list_len > peak_len)
			peak_len = list_len;
		return r;
	endfunction

	task automatic send_req(logic [2:0] op, logic [ID_W-1:0] key, logic [POS_W-1:0] pos,
		bit fixed = 1'b0, result_t want = '0);
		result_t r;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
		end else
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, pos, key};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = apply_list_op(op, key, pos);
		pending_results.push_back(fixed ? want : r);
		n_sent++;
	endtask

	// hold the sender off until every pending result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// receiver: free-running, light or heavy stalling, with the mode switched at random
	int rx_mode = 0;
	int rx_mode_left = 0;
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(50, 400);
		end else
			rx_mode_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	result_t mon_got;
	result_t mon_want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			mon_got.status = m_tuser[2:0];
			mon_got.hit    = m_tuser[3];
			mon_got.id_out = m_tdata[31:0];
			mon_got.count  = m_tdata[42:32];
			if (mon_got.status <= STS_RANGE)
				status_seen[mon_got.status]++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: result with no request pending: status %0d hit %0d id %h count %0d",
						$realtime, mon_got.status, mon_got.hit, mon_got.id_out, mon_got.count);
			end else begin
				mon_want = pending_results.pop_front();
				if (mon_got.status !== mon_want.status || mon_got.hit !== mon_want.hit ||
					mon_got.id_out !== mon_want.id_out || mon_got.count !== mon_want.count) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: result %0d mismatch: exp status %0d hit %0d id %h count %0d, got status %0d hit %0d id %h count %0d",
							$realtime, n_results, mon_want.status, mon_want.hit,
							mon_want.id_out, mon_want.count, mon_got.status, mon_got.hit,
							mon_got.id_out, mon_got.count);
				end
			end
		end
	end

	initial begin
		#150ms;
		$display("tb_dedup_id_list_table: FAIL");
		$finish;
	end

	initial begin
		logic [2:0]       op;
		logic [ID_W-1:0]  key;
		logic [POS_W-1:0] pos;
		int               sel;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_N; k++)
			send_req(DIR_ROWS[k].op, DIR_ROWS[k].key, DIR_ROWS[k].pos, DIR_ROWS[k].fixed,
				DIR_ROWS[k].want);
		drain_results();

		// short lists, often with keys that are present so hits and compaction happen
		for (int k = 0; k < N_RANDOM; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				op = OP_ADD;
			else if (sel < 58)
				op = OP_REMOVE;
			else if (sel < 72)
				op = OP_CONTAINS;
			else if (sel < 90)
				op = OP_READ;
			else if (sel < 93)
				op = OP_CLEAR;
			else
				op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			if (op == OP_ADD && list_len >= 64)
				op = OP_REMOVE;
			if (list_len != 0 && $urandom_range(0, 9) < ((op == OP_ADD) ? 2 : 6))
				key = list_ids[$urandom_range(0, list_len - 1)];
			else
				key = $urandom;
			if ($urandom_range(0, 4) == 0)
				pos = POS_W'($urandom_range(0, LIST_CAP - 1));
			else
				pos = POS_W'($urandom_range(0, list_len));
			send_req(op, key, pos);
			if (k % 120 == 119)
				drain_results();
		end
		drain_results();

		// fill to capacity, with a stray duplicate or read now and then
		while (list_len < LIST_CAP) begin
			sel = $urandom_range(0, 63);
			if (list_len != 0 && sel == 0)
				send_req(OP_ADD, list_ids[$urandom_range(0, list_len - 1)], POS_W'($urandom));
			else if (list_len != 0 && sel == 1)
				send_req(OP_READ, $urandom, POS_W'($urandom_range(0, list_len - 1)));
			else
				send_req(OP_ADD, fresh_id(), POS_W'($urandom));
		end
		send_req(OP_ADD, fresh_id(), '0);
		send_req(OP_ADD, list_ids[LIST_CAP - 1], '0);
		send_req(OP_READ, $urandom, POS_W'(LIST_CAP - 1));
		send_req(OP_CONTAINS, list_ids[0], '0);
		// head removal compacts the whole list
		send_req(OP_REMOVE, list_ids[0], '0);
		send_req(OP_READ, $urandom, '0);
		send_req(OP_ADD, fresh_id(), '0);
		send_req(OP_REMOVE, list_ids[LIST_CAP - 1], '0);
		send_req(OP_READ, $urandom, POS_W'(LIST_CAP - 1));
		send_req(OP_CLEAR, $urandom, '0);
		send_req(OP_READ, $urandom, '0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			n_errors += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end

		$display("ran %0d requests (%0d from the table) and saw %0d results; list peaked at %0d of %0d",
			n_sent, DIR_N, n_results, peak_len, LIST_CAP);
		$display("status mix: ok %0d, duplicate %0d, full %0d, not found %0d, out of range %0d; %0d errors",
			status_seen[STS_OK], status_seen[STS_DUP], status_seen[STS_FULL],
			status_seen[STS_MISS], status_seen[STS_RANGE], n_errors);
		if (n_errors == 0)
			$display("tb_dedup_id_list_table: PASS");
		else
			$display("tb_dedup_id_list_table: FAIL");
		$finish;
	end

endmodule
